/* rtl/assert_macros.svh */
// Assertion shorthands used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, active during reset too.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Concurrent assertion sampled on the rising clock edge, off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

/* rtl/dmxhtp_pkg.sv */
package dmxhtp_pkg;

  // Field widths fixed by the item format
  localparam int LEVEL_W    = 8;
  localparam int CHAN_W     = 12;
  localparam int MODE_W     = 3;
  localparam int UCOUNT_W   = 3;
  localparam int ACC_W      = 24;
  localparam int MUL_W      = 25;

  // One universe is 512 channels
  localparam int UNIVERSE_SIZE = 512;
  localparam int UNIV_SHIFT    = 9;

  // Register map
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_UCOUNT = 1'b0;

  // Level constants
  localparam logic [LEVEL_W-1:0] LEVEL_FULL    = 8'd255;
  localparam logic [LEVEL_W-1:0] SWITCH_THRESH = 8'd127;

  // floor(x/255) = (x * RECIP_255) >> RECIP_SHIFT for every x below 2^24 / 1.0039
  localparam logic [MUL_W-1:0] RECIP_255   = 25'h1010102;
  localparam int               RECIP_SHIFT = 32;

  // Item modes
  typedef enum logic [MODE_W-1:0] {
    MODE_SET_LEVEL     = 3'd0,
    MODE_SET_GRAND     = 3'd1,
    MODE_SET_SEQMASTER = 3'd2,
    MODE_SET_SWITCH    = 3'd3,
    MODE_REFRESH       = 3'd4,
    MODE_READ          = 3'd5
  } mode_t;

  // Operations of the shared arithmetic unit
  typedef enum logic {
    OP_MUL    = 1'b0,
    OP_DIV255 = 1'b1
  } mix_op_t;

  // Request to the shared arithmetic unit
  typedef struct packed {
    mix_op_t              op;
    logic [LEVEL_W-1:0]   factor;
    logic [ACC_W-1:0]     operand;
  } mix_req_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REF_RD,
    ST_REF_CHK,
    ST_MUL_SM,
    ST_MUL_GM,
    ST_DIV_A,
    ST_DIV_B,
    ST_MUL_OUT,
    ST_DIV_OUT,
    ST_DONE
  } state_t;

endpackage

/* rtl/dmxhtp_mix_unit.sv */
// Shared arithmetic unit: one 25x25 multiplier that either scales by a
// fader level or divides by 255 through a reciprocal product.
module dmxhtp_mix_unit (
  input  dmxhtp_pkg::mix_req_t                req,
  output logic [dmxhtp_pkg::ACC_W-1:0]        result
);

  logic [dmxhtp_pkg::MUL_W-1:0]   mul_a;
  logic [dmxhtp_pkg::MUL_W-1:0]   mul_b;
  logic [2*dmxhtp_pkg::MUL_W-1:0] product;

  // Operand selection
  always_comb begin
    unique case (req.op)
      dmxhtp_pkg::OP_MUL: begin
        mul_a = dmxhtp_pkg::MUL_W'(req.factor);
        mul_b = dmxhtp_pkg::MUL_W'(req.operand);
      end
      dmxhtp_pkg::OP_DIV255: begin
        mul_a = dmxhtp_pkg::MUL_W'(req.operand);
        mul_b = dmxhtp_pkg::RECIP_255;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  // Plain product, or the quotient taken from the upper bits
  always_comb begin
    unique case (req.op)
      dmxhtp_pkg::OP_MUL:    result = product[dmxhtp_pkg::ACC_W-1:0];
      dmxhtp_pkg::OP_DIV255: result = dmxhtp_pkg::ACC_W'(product >> dmxhtp_pkg::RECIP_SHIFT);
      default:               result = '0;
    endcase
  end

endmodule

/* rtl/dmx_htp_channel_mixer.sv */
// Simple items (level, master, switching, read): the result is registered in DONE
// once the result register is free; no new item is taken until the block is idle.
// Refresh: 512*universe_count channel visits (none when nothing is dirty); a visit
// reads and checks the channel, and a recomputed channel takes six multiplier steps.
// Reset and every change of universe count run a clearing sweep over all
// MAX_UNIVERSES*512 channels, one channel a cycle, during which items stall.
module dmx_htp_channel_mixer #(
  parameter int MAX_UNIVERSES = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  // item channel
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [dmxhtp_pkg::MODE_W-1:0]     mode,
  input  logic                              source,
  input  logic [dmxhtp_pkg::CHAN_W-1:0]     channel,
  input  logic [dmxhtp_pkg::LEVEL_W-1:0]    level_value,
  input  logic                              switch_on,
  // result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [dmxhtp_pkg::LEVEL_W-1:0]    out_level,
  output logic                              accepted,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dmxhtp_pkg::PADDR_W-1:0]    paddr,
  input  logic [dmxhtp_pkg::PDATA_W-1:0]    pwdata,
  output logic [dmxhtp_pkg::PDATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int DEPTH  = MAX_UNIVERSES * dmxhtp_pkg::UNIVERSE_SIZE;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int WIDE_W = ((IDX_W > dmxhtp_pkg::CHAN_W) ? IDX_W : dmxhtp_pkg::CHAN_W) + 1;
  localparam int LW     = dmxhtp_pkg::LEVEL_W;
  localparam int UW     = dmxhtp_pkg::UCOUNT_W;

  // ---------------------------------------------------------------- state
  dmxhtp_pkg::state_t state, state_next;

  logic [UW-1:0]     ucount;
  logic [LW-1:0]     grand_manual, grand_sequence;
  logic [LW-1:0]     seqmaster_manual, seqmaster_sequence;
  logic              all_dirty, any_dirty;

  logic [IDX_W-1:0]  clr_idx;
  logic [UW-1:0]     clr_limit;
  logic              clr_all;

  logic [IDX_W-1:0]  ridx;
  logic [LW-1:0]     gm, sm;
  logic [dmxhtp_pkg::ACC_W-1:0] acc;

  logic              res_ok, res_read;

  // Channel memories
  logic [LW-1:0] man_mem   [DEPTH];
  logic [LW-1:0] seq_mem   [DEPTH];
  logic [LW-1:0] out_mem   [DEPTH];
  logic          dirty_mem [DEPTH];
  logic          sw_mem    [DEPTH];

  logic [LW-1:0] rd_man, rd_seq, rd_out;
  logic          rd_dirty, rd_sw;

  // ---------------------------------------------------------------- decode
  dmxhtp_pkg::mode_t item_mode;
  logic              item_xfer;
  logic              ch_ok;
  logic [IDX_W-1:0]  ch_idx;
  logic [WIDE_W-1:0] ch_limit;

  assign item_mode = dmxhtp_pkg::mode_t'(mode);
  assign item_xfer = item_valid && !item_stall;
  assign ch_limit  = WIDE_W'(ucount) << dmxhtp_pkg::UNIV_SHIFT;
  assign ch_ok     = (channel != '0) && (WIDE_W'(channel) <= ch_limit);
  assign ch_idx    = IDX_W'(channel - dmxhtp_pkg::CHAN_W'(1));

  // Configuration write decode
  logic          cfg_wr;
  logic [UW-1:0] n_raw, n_sat;
  logic          cfg_change;

  assign cfg_wr     = psel && penable && pwrite && pready
                      && (paddr[dmxhtp_pkg::PADDR_W-1] == dmxhtp_pkg::REG_UCOUNT);
  assign n_raw      = pwdata[UW-1:0];
  assign n_sat      = (32'(n_raw) > MAX_UNIVERSES) ? UW'(MAX_UNIVERSES) : n_raw;
  assign cfg_change = cfg_wr && (n_raw != '0) && (n_sat != ucount);

  assign pready = 1'b1;
  assign prdata = (paddr[dmxhtp_pkg::PADDR_W-1] == dmxhtp_pkg::REG_UCOUNT)
                  ? dmxhtp_pkg::PDATA_W'(ucount) : '0;

  // Sweep and refresh bounds
  logic clr_last, clr_beyond, ref_last;
  assign clr_last   = (clr_idx == IDX_W'(DEPTH - 1));
  assign clr_beyond = (WIDE_W'(clr_idx) >> dmxhtp_pkg::UNIV_SHIFT) >= WIDE_W'(clr_limit);
  assign ref_last   = (WIDE_W'(ridx) == (ch_limit - WIDE_W'(1)));

  // Mix data path
  dmxhtp_pkg::mix_req_t    unit_req;
  logic [dmxhtp_pkg::ACC_W-1:0] unit_res;
  logic [LW-1:0]           lvl_max, pre, pre_sw;
  logic [2*LW-1:0]         man_full, top;

  dmxhtp_mix_unit u_unit (
    .req    (unit_req),
    .result (unit_res)
  );

  assign lvl_max  = (rd_man > rd_seq) ? rd_man : rd_seq;
  assign man_full = ({rd_man, {LW{1'b0}}}) - (2*LW)'(rd_man);
  assign top      = (man_full > unit_res[2*LW-1:0]) ? man_full : unit_res[2*LW-1:0];
  assign pre      = acc[LW-1:0];
  assign pre_sw   = !rd_sw ? pre
                    : ((pre >= dmxhtp_pkg::SWITCH_THRESH) ? dmxhtp_pkg::LEVEL_FULL : '0);

  logic gm_zero, ref_visit_done, ref_finish, out_free;
  assign gm_zero        = (gm == '0);
  assign ref_visit_done = ((state == dmxhtp_pkg::ST_REF_CHK)
                           && (gm_zero || !(rd_dirty || all_dirty)))
                          || (state == dmxhtp_pkg::ST_DIV_OUT);
  assign ref_finish     = ref_visit_done && ref_last;
  assign out_free       = !result_valid || !result_stall;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      dmxhtp_pkg::ST_CLEAR: begin
        if (clr_last) state_next = dmxhtp_pkg::ST_IDLE;
      end
      dmxhtp_pkg::ST_IDLE: begin
        if (item_xfer) begin
          if (item_mode == dmxhtp_pkg::MODE_REFRESH && any_dirty) begin
            state_next = dmxhtp_pkg::ST_REF_RD;
          end else begin
            state_next = dmxhtp_pkg::ST_DONE;
          end
        end
      end
      dmxhtp_pkg::ST_REF_RD:  state_next = dmxhtp_pkg::ST_REF_CHK;
      dmxhtp_pkg::ST_REF_CHK: begin
        if (!ref_visit_done) begin
          state_next = dmxhtp_pkg::ST_MUL_SM;
        end else begin
          state_next = ref_last ? dmxhtp_pkg::ST_DONE : dmxhtp_pkg::ST_REF_RD;
        end
      end
      dmxhtp_pkg::ST_MUL_SM:  state_next = dmxhtp_pkg::ST_MUL_GM;
      dmxhtp_pkg::ST_MUL_GM:  state_next = dmxhtp_pkg::ST_DIV_A;
      dmxhtp_pkg::ST_DIV_A:   state_next = dmxhtp_pkg::ST_DIV_B;
      dmxhtp_pkg::ST_DIV_B:   state_next = dmxhtp_pkg::ST_MUL_OUT;
      dmxhtp_pkg::ST_MUL_OUT: state_next = dmxhtp_pkg::ST_DIV_OUT;
      dmxhtp_pkg::ST_DIV_OUT: begin
        state_next = ref_last ? dmxhtp_pkg::ST_DONE : dmxhtp_pkg::ST_REF_RD;
      end
      dmxhtp_pkg::ST_DONE: begin
        if (out_free) state_next = dmxhtp_pkg::ST_IDLE;
      end
      default: state_next = dmxhtp_pkg::ST_CLEAR;
    endcase
    // a new universe count restarts the clearing sweep
    if (cfg_change) state_next = dmxhtp_pkg::ST_CLEAR;
  end

  // ---------------------------------------------------------------- outputs
  logic             man_we, seq_we, out_we, dirty_we, sw_we;
  logic [IDX_W-1:0] lvl_wa, out_wa, dirty_wa, sw_wa;
  logic [LW-1:0]    lvl_wd, out_wd;
  logic             dirty_wd, sw_wd;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;

  always_comb begin
    item_stall = (state != dmxhtp_pkg::ST_IDLE) || cfg_change;
    man_we   = 1'b0;
    seq_we   = 1'b0;
    out_we   = 1'b0;
    dirty_we = 1'b0;
    sw_we    = 1'b0;
    lvl_wa   = ch_idx;
    lvl_wd   = level_value;
    out_wa   = ridx;
    out_wd   = '0;
    dirty_wa = ridx;
    dirty_wd = 1'b0;
    sw_wa    = ch_idx;
    sw_wd    = switch_on;
    rd_en    = 1'b0;
    rd_addr  = ridx;
    unit_req = '{op: dmxhtp_pkg::OP_MUL, factor: '0, operand: '0};

    unique case (state)
      dmxhtp_pkg::ST_CLEAR: begin
        out_we   = 1'b1;
        out_wa   = clr_idx;
        lvl_wa   = clr_idx;
        lvl_wd   = '0;
        man_we   = clr_beyond;
        seq_we   = clr_beyond;
        dirty_we = clr_beyond;
        dirty_wa = clr_idx;
        dirty_wd = 1'b1;
        sw_we    = clr_all;
        sw_wa    = clr_idx;
        sw_wd    = 1'b0;
      end
      dmxhtp_pkg::ST_IDLE: begin
        rd_en   = item_xfer;
        rd_addr = ch_idx;
        if (item_xfer && ch_ok) begin
          if (item_mode == dmxhtp_pkg::MODE_SET_LEVEL) begin
            man_we   = !source;
            seq_we   = source;
            dirty_we = 1'b1;
            dirty_wa = ch_idx;
            dirty_wd = 1'b1;
          end
          if (item_mode == dmxhtp_pkg::MODE_SET_SWITCH) sw_we = 1'b1;
        end
      end
      dmxhtp_pkg::ST_REF_RD: rd_en = 1'b1;
      dmxhtp_pkg::ST_REF_CHK: begin
        // grand master at zero: blank the output, keep the dirty flag
        out_we = gm_zero;
      end
      dmxhtp_pkg::ST_MUL_SM: begin
        unit_req = '{op: dmxhtp_pkg::OP_MUL, factor: sm,
                     operand: dmxhtp_pkg::ACC_W'(lvl_max)};
      end
      dmxhtp_pkg::ST_MUL_GM: begin
        unit_req = '{op: dmxhtp_pkg::OP_MUL, factor: gm, operand: acc};
      end
      dmxhtp_pkg::ST_DIV_A, dmxhtp_pkg::ST_DIV_B: begin
        unit_req = '{op: dmxhtp_pkg::OP_DIV255, factor: '0, operand: acc};
      end
      dmxhtp_pkg::ST_MUL_OUT: begin
        unit_req = '{op: dmxhtp_pkg::OP_MUL, factor: gm,
                     operand: dmxhtp_pkg::ACC_W'(pre_sw)};
      end
      dmxhtp_pkg::ST_DIV_OUT: begin
        unit_req = '{op: dmxhtp_pkg::OP_DIV255, factor: '0, operand: acc};
        out_we   = 1'b1;
        out_wd   = unit_res[LW-1:0];
        dirty_we = 1'b1;
        dirty_wd = 1'b0;
      end
      dmxhtp_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (man_we) man_mem[lvl_wa] <= lvl_wd;
    if (rd_en)  rd_man <= man_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (seq_we) seq_mem[lvl_wa] <= lvl_wd;
    if (rd_en)  rd_seq <= seq_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (out_we) out_mem[out_wa] <= out_wd;
    if (rd_en)  rd_out <= out_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (dirty_we) dirty_mem[dirty_wa] <= dirty_wd;
    if (rd_en)    rd_dirty <= dirty_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (sw_we) sw_mem[sw_wa] <= sw_wd;
    if (rd_en) rd_sw <= sw_mem[rd_addr];
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= dmxhtp_pkg::ST_CLEAR;
      ucount             <= UW'(1);
      grand_manual       <= dmxhtp_pkg::LEVEL_FULL;
      grand_sequence     <= '0;
      seqmaster_manual   <= dmxhtp_pkg::LEVEL_FULL;
      seqmaster_sequence <= '0;
      all_dirty          <= 1'b0;
      any_dirty          <= 1'b1;
      clr_idx            <= '0;
      clr_limit          <= '0;
      clr_all            <= 1'b1;
      result_valid       <= 1'b0;
    end else begin
      state <= state_next;

      // clearing sweep
      if (state == dmxhtp_pkg::ST_CLEAR && !cfg_change) clr_idx <= clr_idx + IDX_W'(1);

      // universe count change
      if (cfg_change) begin
        ucount    <= n_sat;
        all_dirty <= 1'b1;
        any_dirty <= 1'b1;
        clr_idx   <= '0;
        if (state == dmxhtp_pkg::ST_CLEAR) begin
          clr_limit <= (n_sat < clr_limit) ? n_sat : clr_limit;
        end else begin
          clr_limit <= n_sat;
          clr_all   <= 1'b0;
        end
      end else if (item_xfer) begin
        unique case (item_mode)
          dmxhtp_pkg::MODE_SET_LEVEL: begin
            if (ch_ok) any_dirty <= 1'b1;
          end
          dmxhtp_pkg::MODE_SET_GRAND: begin
            if (source) grand_sequence <= level_value;
            else        grand_manual   <= level_value;
            all_dirty <= 1'b1;
            any_dirty <= 1'b1;
          end
          dmxhtp_pkg::MODE_SET_SEQMASTER: begin
            if (source) seqmaster_sequence <= level_value;
            else        seqmaster_manual   <= level_value;
            all_dirty <= 1'b1;
            any_dirty <= 1'b1;
          end
          dmxhtp_pkg::MODE_SET_SWITCH: begin
            if (ch_ok) all_dirty <= 1'b1;
          end
          default: ;
        endcase
      end else if (ref_finish) begin
        all_dirty <= 1'b0;
        any_dirty <= 1'b0;
      end

      // result register
      if (state == dmxhtp_pkg::ST_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- data registers
  always_ff @(posedge clk) begin
    // item latch
    if (item_xfer) begin
      ridx     <= '0;
      gm       <= (grand_manual > grand_sequence) ? grand_manual : grand_sequence;
      sm       <= (seqmaster_manual > seqmaster_sequence) ? seqmaster_manual
                                                          : seqmaster_sequence;
      res_read <= (item_mode == dmxhtp_pkg::MODE_READ) && ch_ok;
      unique case (item_mode)
        dmxhtp_pkg::MODE_SET_GRAND,
        dmxhtp_pkg::MODE_SET_SEQMASTER,
        dmxhtp_pkg::MODE_REFRESH:       res_ok <= 1'b1;
        dmxhtp_pkg::MODE_SET_LEVEL,
        dmxhtp_pkg::MODE_SET_SWITCH,
        dmxhtp_pkg::MODE_READ:          res_ok <= ch_ok;
        default:                        res_ok <= 1'b0;
      endcase
    end

    // next channel of the refresh
    if (ref_visit_done && !ref_last) ridx <= ridx + IDX_W'(1);

    // accumulator of the mix sequence
    unique case (state)
      dmxhtp_pkg::ST_MUL_SM:  acc <= dmxhtp_pkg::ACC_W'(top);
      dmxhtp_pkg::ST_MUL_GM,
      dmxhtp_pkg::ST_DIV_A,
      dmxhtp_pkg::ST_DIV_B,
      dmxhtp_pkg::ST_MUL_OUT: acc <= unit_res;
      default: ;
    endcase

    // result payload
    if (state == dmxhtp_pkg::ST_DONE && out_free) begin
      out_level <= res_read ? rd_out : '0;
      accepted  <= res_ok;
    end
  end

endmodule

/* rtl/dmxhtp_checker.sv */
`include "assert_macros.svh"

// Port-level checks of the channel mixer.
module dmxhtp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           item_valid,
  input logic                           item_stall,
  input logic                           result_valid,
  input logic                           result_stall,
  input logic [dmxhtp_pkg::LEVEL_W-1:0] out_level,
  input logic                           accepted
);

  // a stalled result stays offered
  `ASSERT_CLK_RST(a_result_hold, clk, rst, result_valid && result_stall |=> result_valid, "stalled result dropped")

  // a stalled result keeps its payload
  `ASSERT_CLK_RST(a_result_stable, clk, rst, result_valid && result_stall |=> $stable(out_level) && $stable(accepted), "stalled result changed")

  // reset starts the clearing sweep, so no item is taken right after it
  `ASSERT_CLK(a_reset_sweep, clk, rst |=> item_stall, "item taken right after reset")

  // one item at a time: the block is busy after every input transfer
  `ASSERT_CLK_RST(a_one_item, clk, rst, item_valid && !item_stall |=> item_stall, "second item taken back to back")

endmodule

bind dmx_htp_channel_mixer dmxhtp_checker u_dmxhtp_checker (.*);

/* tb/dmx_mix_checker.sv */
`timescale 1ns / 1ps

// Watches the item, result and configuration ports of the channel mixer,
// keeps its own copy of the mixer state and checks every result in order.
module dmx_mix_checker #(
  parameter int MAX_UNIVERSES = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  input  logic                            item_stall,
  input  logic [dmxhtp_pkg::MODE_W-1:0]   mode,
  input  logic                            source,
  input  logic [dmxhtp_pkg::CHAN_W-1:0]   channel,
  input  logic [dmxhtp_pkg::LEVEL_W-1:0]  level_value,
  input  logic                            switch_on,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  logic [dmxhtp_pkg::LEVEL_W-1:0]  out_level,
  input  logic                            accepted,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dmxhtp_pkg::PADDR_W-1:0]  paddr,
  input  logic [dmxhtp_pkg::PDATA_W-1:0]  pwdata,
  input  logic [dmxhtp_pkg::PDATA_W-1:0]  prdata,
  input  logic                            pready,
  output int                              errors,
  output int                              pending
);

  localparam int DEPTH = MAX_UNIVERSES * dmxhtp_pkg::UNIVERSE_SIZE;
  localparam int LW = dmxhtp_pkg::LEVEL_W;
  localparam int unsigned FULL = dmxhtp_pkg::LEVEL_FULL;
  localparam int unsigned FULL_SQ = FULL * FULL;

  typedef struct packed {
    logic [LW-1:0] level;
    logic          acc;
  } mix_result_t;

  // mirrored mixer state
  logic [LW-1:0]      man_lvl   [DEPTH];
  logic [LW-1:0]      seq_lvl   [DEPTH];
  logic [LW-1:0]      out_store [DEPTH];
  bit                 chan_dirty [DEPTH];
  bit                 chan_switched [DEPTH];
  logic [LW-1:0]      grand_man, grand_seq, smaster_man, smaster_seq;
  bit                 dirty_all, dirty_any;
  int unsigned        units;

  mix_result_t        expected_q [$];
  int                 fail_count;

  function automatic int unsigned live_channels();
    return units * dmxhtp_pkg::UNIVERSE_SIZE;
  endfunction

  function automatic void clear_model();
    for (int i = 0; i < DEPTH; i++) begin
      man_lvl[i] = '0;
      seq_lvl[i] = '0;
      out_store[i] = '0;
      chan_dirty[i] = 1'b1;
      chan_switched[i] = 1'b0;
    end
    grand_man = dmxhtp_pkg::LEVEL_FULL;
    grand_seq = '0;
    smaster_man = dmxhtp_pkg::LEVEL_FULL;
    smaster_seq = '0;
    dirty_all = 1'b0;
    dirty_any = 1'b1;
    units = 1;
  endfunction

  // HTP mix of one channel, then the grand master scaling
  function automatic logic [LW-1:0] mix_level(int idx, int unsigned gm, int unsigned sm);
    int unsigned m, s, hi, top, pre;
    m = man_lvl[idx];
    s = seq_lvl[idx];
    hi = (m > s) ? m : s;
    top = FULL * m;
    if (hi * sm > top) top = hi * sm;
    pre = (gm * top) / FULL_SQ;
    if (chan_switched[idx]) pre = (pre >= dmxhtp_pkg::SWITCH_THRESH) ? FULL : 0;
    return LW'((pre * gm) / FULL);
  endfunction

  function automatic void refresh_outputs();
    int unsigned gm, sm;
    gm = (grand_man > grand_seq) ? grand_man : grand_seq;
    sm = (smaster_man > smaster_seq) ? smaster_man : smaster_seq;
    if (!dirty_any) return;
    for (int i = 0; i < int'(live_channels()); i++) begin
      if (gm == 0) begin
        out_store[i] = '0;
      end else if (chan_dirty[i] || dirty_all) begin
        out_store[i] = mix_level(i, gm, sm);
        chan_dirty[i] = 1'b0;
      end
    end
    dirty_all = 1'b0;
    dirty_any = 1'b0;
  endfunction

  // universe count write: zero ignored, large values saturate
  function automatic void set_units(logic [dmxhtp_pkg::PDATA_W-1:0] value);
    int unsigned n;
    n = value[dmxhtp_pkg::UCOUNT_W-1:0];
    if (n == 0) return;
    if (n > MAX_UNIVERSES) n = MAX_UNIVERSES;
    if (n == units) return;
    units = n;
    for (int i = int'(live_channels()); i < DEPTH; i++) begin
      man_lvl[i] = '0;
      seq_lvl[i] = '0;
      chan_dirty[i] = 1'b1;
    end
    for (int i = 0; i < DEPTH; i++) out_store[i] = '0;
    dirty_all = 1'b1;
    dirty_any = 1'b1;
  endfunction

  function automatic mix_result_t apply_item(logic [dmxhtp_pkg::MODE_W-1:0] m, logic src,
                                             logic [dmxhtp_pkg::CHAN_W-1:0] ch,
                                             logic [LW-1:0] lv, logic sw);
    mix_result_t r;
    bit ch_ok;
    int idx;
    r = '0;
    ch_ok = (ch >= 1) && (ch <= live_channels());
    idx = int'(ch) - 1;
    case (m)
      dmxhtp_pkg::MODE_SET_LEVEL: begin
        if (ch_ok) begin
          if (src) seq_lvl[idx] = lv;
          else man_lvl[idx] = lv;
          chan_dirty[idx] = 1'b1;
          dirty_any = 1'b1;
          r.acc = 1'b1;
        end
      end
      dmxhtp_pkg::MODE_SET_GRAND: begin
        if (src) grand_seq = lv;
        else grand_man = lv;
        dirty_all = 1'b1;
        dirty_any = 1'b1;
        r.acc = 1'b1;
      end
      dmxhtp_pkg::MODE_SET_SEQMASTER: begin
        if (src) smaster_seq = lv;
        else smaster_man = lv;
        dirty_all = 1'b1;
        dirty_any = 1'b1;
        r.acc = 1'b1;
      end
      dmxhtp_pkg::MODE_SET_SWITCH: begin
        // only marks everything stale; the next dirty refresh picks it up
        if (ch_ok) begin
          chan_switched[idx] = sw;
          dirty_all = 1'b1;
          r.acc = 1'b1;
        end
      end
      dmxhtp_pkg::MODE_REFRESH: begin
        refresh_outputs();
        r.acc = 1'b1;
      end
      dmxhtp_pkg::MODE_READ: begin
        if (ch_ok) begin
          r.level = out_store[idx];
          r.acc = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // monitor: config writes, register reads, item and result transfers
  always @(posedge clk) begin : watch
    mix_result_t want, got;
    if (rst) begin
      clear_model();
      expected_q.delete();
    end else begin
      if (psel && penable && pready
          && paddr[dmxhtp_pkg::PADDR_W-1:2] == dmxhtp_pkg::REG_UCOUNT) begin
        if (pwrite) begin
          set_units(pwdata);
        end else if (prdata !== dmxhtp_pkg::PDATA_W'(units)) begin
          $display("%0t: universe count read expected %0d, got %0d", $time, units, prdata);
          fail_count++;
        end
      end
      if (item_valid && !item_stall)
        expected_q.push_back(apply_item(mode, source, channel, level_value, switch_on));
      if (result_valid && !result_stall) begin
        got.level = out_level;
        got.acc = accepted;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result transfer, out_level %0d accepted %0d",
                   $time, got.level, got.acc);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.level !== want.level) begin
            $display("%0t: out_level expected %0d, got %0d", $time, want.level, got.level);
            fail_count++;
          end
          if (got.acc !== want.acc) begin
            $display("%0t: accepted expected %0d, got %0d", $time, want.acc, got.acc);
            fail_count++;
          end
        end
      end
    end
    pending <= expected_q.size();
    errors <= fail_count;
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

// Stimulus for the channel mixer: a directed opening, then random phases at
// several universe counts and idle patterns. Checking lives in the checker.
module tb;

  localparam int MAX_UNITS = 4;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int NUM_PHASES = 8;
  localparam int MW = dmxhtp_pkg::MODE_W;
  localparam int CW = dmxhtp_pkg::CHAN_W;
  localparam int LW = dmxhtp_pkg::LEVEL_W;
  localparam int AW = dmxhtp_pkg::PADDR_W;
  localparam int DW = dmxhtp_pkg::PDATA_W;
  localparam int USIZE = dmxhtp_pkg::UNIVERSE_SIZE;
  localparam logic [MW-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MW-1:0] MODE_SPARE_B = 3'd7;
  localparam logic [AW-1:0] UCOUNT_ADDR = AW'({dmxhtp_pkg::REG_UCOUNT, 2'b00});

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_stall;
  logic [MW-1:0]       mode;
  logic                source;
  logic [CW-1:0]       channel;
  logic [LW-1:0]       level_value;
  logic                switch_on;
  logic                result_valid;
  logic                result_stall;
  logic [LW-1:0]       out_level;
  logic                accepted;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AW-1:0]       paddr;
  logic [DW-1:0]       pwdata;
  logic [DW-1:0]       prdata;
  logic                pready;
  int                  errors;
  int                  pending;

  int                  send_idle_pct;
  int                  stall_pct;
  int unsigned         cur_units;
  int unsigned         win_base;
  int unsigned         cycle_count;

  // universe count per phase (phase 0 keeps the reset value) and item count
  int unsigned phase_cfg   [NUM_PHASES] = '{1, 4, 2, 0, 7, 3, 1, 1};
  int unsigned phase_items [NUM_PHASES] = '{400, 150, 250, 200, 150, 200, 300, 300};

  dmx_htp_channel_mixer #(.MAX_UNIVERSES(MAX_UNITS)) dut (.*);

  dmx_mix_checker #(.MAX_UNIVERSES(MAX_UNITS)) u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // one item transfer, with random idle cycles ahead of it
  task automatic send_item(input logic [MW-1:0] m, input logic src, input int unsigned ch,
                           input logic [LW-1:0] lv, input logic sw);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    mode <= m;
    source <= src;
    channel <= CW'(ch);
    level_value <= lv;
    switch_on <= sw;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [AW-1:0] addr,
                            input logic [DW-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // random item: mostly level writes and reads on a small channel window,
  // refreshes kept rarer at high universe counts since they sweep every channel
  task automatic send_random();
    int unsigned r, live, ch;
    logic [MW-1:0] m;
    logic [LW-1:0] lv;
    live = cur_units * USIZE;
    r = $urandom_range(99);
    if (r < 8 / cur_units) begin
      m = dmxhtp_pkg::MODE_REFRESH;
    end else begin
      r = $urandom_range(99);
      if (r < 32) m = dmxhtp_pkg::MODE_SET_LEVEL;
      else if (r < 38) m = dmxhtp_pkg::MODE_SET_GRAND;
      else if (r < 44) m = dmxhtp_pkg::MODE_SET_SEQMASTER;
      else if (r < 52) m = dmxhtp_pkg::MODE_SET_SWITCH;
      else if (r < 97) m = dmxhtp_pkg::MODE_READ;
      else m = r[0] ? MODE_SPARE_A : MODE_SPARE_B;
    end
    r = $urandom_range(99);
    if (r < 70) ch = win_base + $urandom_range(15);
    else if (r < 80) ch = $urandom_range(live, 1);
    else if (r < 85) ch = live;
    else if (r < 90) ch = 0;
    else ch = $urandom_range((1 << CW) - 1);
    r = $urandom_range(99);
    if (r < 15) lv = '0;
    else if (r < 30) lv = dmxhtp_pkg::LEVEL_FULL;
    else lv = LW'($urandom_range(255));
    send_item(m, 1'($urandom_range(1)), ch, lv, 1'($urandom_range(1)));
  endtask

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    mode = dmxhtp_pkg::MODE_SET_LEVEL;
    source = 1'b0;
    channel = '0;
    level_value = '0;
    switch_on = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    cur_units = 1;
    win_base = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset value of the universe count
    apb_access(1'b0, UCOUNT_ADDR, '0);

    // directed opening at one universe
    send_item(dmxhtp_pkg::MODE_READ, 1'b0, 0, 8'h00, 1'b0);
    send_item(dmxhtp_pkg::MODE_READ, 1'b0, 1, 8'h00, 1'b0);
    send_item(dmxhtp_pkg::MODE_SET_LEVEL, 1'b0, 1, 8'hFF, 1'b0);
    send_item(dmxhtp_pkg::MODE_SET_LEVEL, 1'b1, USIZE, 8'd200, 1'b0);
    send_item(dmxhtp_pkg::MODE_SET_LEVEL, 1'b0, 4095, 8'hAA, 1'b1);
    send_item(dmxhtp_pkg::MODE_SET_LEVEL, 1'b0, 2, 8'd127, 1'b0);
    send_item(dmxhtp_pkg::MODE_SET_LEVEL, 1'b0, 3, 8'd126, 1'b0);
    send_item(dmxhtp_pkg::MODE_SET_SWITCH, 1'b0, 2, 8'h00, 1'b1);
    send_item(dmxhtp_pkg::MODE_SET_SWITCH, 1'b0, 3, 8'h00, 1'b1);
    send_item(dmxhtp_pkg::MODE_SET_SEQMASTER, 1'b1, 0, 8'd128, 1'b0);
    send_item(dmxhtp_pkg::MODE_REFRESH, 1'b0, 0, 8'h00, 1'b0);
    send_item(dmxhtp_pkg::MODE_READ, 1'b0, 1, 8'h00, 1'b0);
    send_item(dmxhtp_pkg::MODE_READ, 1'b0, 2, 8'h00, 1'b0);
    send_item(dmxhtp_pkg::MODE_READ, 1'b0, 3, 8'h00, 1'b0);
    send_item(dmxhtp_pkg::MODE_READ, 1'b0, USIZE, 8'h00, 1'b0);
    send_item(dmxhtp_pkg::MODE_READ, 1'b0, USIZE + 1, 8'h00, 1'b0);
    send_item(MODE_SPARE_A, 1'b1, 12'hFFF, 8'h55, 1'b1);
    send_item(MODE_SPARE_B, 1'b0, 12'h555, 8'hAA, 1'b0);
    // switching change alone leaves the refresh idle
    send_item(dmxhtp_pkg::MODE_SET_SWITCH, 1'b0, 1, 8'h00, 1'b1);
    send_item(dmxhtp_pkg::MODE_REFRESH, 1'b0, 0, 8'h00, 1'b0);
    send_item(dmxhtp_pkg::MODE_READ, 1'b0, 1, 8'h00, 1'b0);
    // grand master at zero blacks out everything
    send_item(dmxhtp_pkg::MODE_SET_GRAND, 1'b0, 0, 8'h00, 1'b0);
    send_item(dmxhtp_pkg::MODE_REFRESH, 1'b0, 0, 8'h00, 1'b0);
    send_item(dmxhtp_pkg::MODE_READ, 1'b0, USIZE, 8'h00, 1'b0);
    send_item(dmxhtp_pkg::MODE_SET_GRAND, 1'b0, 0, 8'hFF, 1'b0);

    // random phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        drain();
        apb_access(1'b1, UCOUNT_ADDR, DW'(phase_cfg[p]));
        if (phase_cfg[p] != 0)
          cur_units = (phase_cfg[p] > MAX_UNITS) ? MAX_UNITS : phase_cfg[p];
        apb_access(1'b0, UCOUNT_ADDR, '0);
      end
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 64;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 64;
        end
        default: begin
          send_idle_pct = 17;
          stall_pct = 17;
        end
      endcase
      win_base = $urandom_range(cur_units * USIZE - 15, 1);
      repeat (phase_items[p]) send_random();
    end

    drain();
    stall_pct = 0;
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/dmxhtp_pkg.sv
rtl/dmxhtp_mix_unit.sv
rtl/dmx_htp_channel_mixer.sv
rtl/dmxhtp_checker.sv
tb/dmx_mix_checker.sv
tb/tb.sv
